// File: src/ksts_pkg.sv
// Shared sizes, operation codes and status codes of the keyed serial task scheduler.
package ksts_pkg;

  localparam int unsigned NUM_KEYS    = 16;
  localparam int unsigned WAIT_DEPTH  = 8;
  localparam int unsigned READY_DEPTH = 32;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned KEY_W    = 4;
  localparam int unsigned TASK_W   = 8;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned KEY_IDX_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned WAIT_PTR_W   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned WAIT_CNT_W   = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned READY_PTR_W  = $clog2(READY_DEPTH);
  localparam int unsigned READY_CNT_W  = $clog2(READY_DEPTH + 1);
  localparam int unsigned WAIT_ENTRIES = NUM_KEYS * WAIT_DEPTH;
  localparam int unsigned WAIT_ADDR_W  = (WAIT_ENTRIES > 1) ? $clog2(WAIT_ENTRIES) : 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLAIN   = 3'd0,
    KIND_KEYED   = 3'd1,
    KIND_RELEASE = 3'd2,
    KIND_DEQUEUE = 3'd3,
    KIND_INIT    = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_READY_FULL  = 3'd1,
    ST_WAIT_FULL   = 3'd2,
    ST_READY_EMPTY = 3'd3,
    ST_KEY_UNINIT  = 3'd4
  } status_e;

endpackage

// File: src/keyed_serial_task_scheduler_core.sv
// Keyed serial task scheduler: a ready deque with per-key serialization FIFOs.
//
// The block takes one operation per transfer on the input channel and returns exactly one result
// transfer for it. Operations are plain enqueue (to the back of the ready queue), keyed enqueue
// (to the front of the ready queue when the key is free, which makes it busy, or else into the
// key's waiting FIFO), release of a key (its oldest waiting task moves to the ready front, or the
// key becomes free), dequeue (pops the ready front) and key initialization (marks the key free and
// empties its FIFO). Error status leaves all state untouched. A new operation can be accepted in
// every cycle while the output side does not stall, so the sustained rate is one operation per
// clock. The operation is captured in an operation register while the waiting-FIFO memory is
// read at the key's head; when it retires, the update is applied and the result register is
// loaded. Both the operation register and the result register hold when the output side
// stalls, and the input stalls only while both are full. There is no clearing pass after reset:
// the waiting memory is read on every acceptance, but only entries written earlier are ever used.
module keyed_serial_task_scheduler_core
  import ksts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [TASK_W-1:0]   task_id_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                task_valid_o,
  output logic [TASK_W-1:0]   task_out_o,
  output logic [STATUS_W-1:0] status_o
);

  // Address of one entry in the shared waiting memory.
  function automatic logic [WAIT_ADDR_W-1:0] wait_addr(input logic [KEY_IDX_W-1:0] idx,
                                                        input logic [WAIT_PTR_W-1:0] ptr);
    wait_addr = WAIT_ADDR_W'(int'(idx) * WAIT_DEPTH + int'(ptr));
  endfunction

  // Handshake and operation register.
  logic              in_accept;
  logic              res_ready;
  logic              s1_fire;
  logic              s1_valid_q;
  logic [KIND_W-1:0] s1_kind_q;
  logic [KEY_W-1:0]  s1_key_q;
  logic [TASK_W-1:0] s1_task_q;

  // Result register.
  logic                out_valid_q;
  logic                task_valid_q;
  logic [TASK_W-1:0]   task_out_q;
  logic [STATUS_W-1:0] status_q;
  logic                res_task_valid;
  logic [TASK_W-1:0]   res_task;
  status_e             res_status;

  // Ready deque.
  logic [TASK_W-1:0]      ready_store_q [READY_DEPTH];
  logic [READY_PTR_W-1:0] ready_head_q, ready_head_d;
  logic [READY_CNT_W-1:0] ready_count_q, ready_count_d;
  logic                   rs_we;
  logic [READY_PTR_W-1:0] rs_waddr;
  logic [TASK_W-1:0]      rs_wdata;
  logic [READY_CNT_W:0]   ready_tail_sum;
  logic [READY_PTR_W-1:0] ready_tail;
  logic [READY_PTR_W-1:0] ready_front;
  logic                   ready_full;

  // Per-key state.
  logic                  key_known_q [NUM_KEYS];
  logic                  key_known_d [NUM_KEYS];
  logic                  key_free_q  [NUM_KEYS];
  logic                  key_free_d  [NUM_KEYS];
  logic [WAIT_PTR_W-1:0] wait_head_q [NUM_KEYS];
  logic [WAIT_PTR_W-1:0] wait_head_d [NUM_KEYS];
  logic [WAIT_CNT_W-1:0] wait_count_q [NUM_KEYS];
  logic [WAIT_CNT_W-1:0] wait_count_d [NUM_KEYS];

  logic [KEY_IDX_W-1:0]  s1_idx;
  logic                  s1_key_ok;
  logic                  s1_in_range;
  logic [WAIT_PTR_W-1:0] s1_wh;
  logic [WAIT_CNT_W-1:0] s1_wc;
  logic [WAIT_CNT_W:0]   wait_tail_sum;
  logic [WAIT_PTR_W-1:0] wait_tail;
  logic [WAIT_PTR_W-1:0] wait_head_next;

  // Waiting memory ports and write-to-read bypass.
  logic                   ws_we;
  logic [WAIT_ADDR_W-1:0] ws_waddr;
  logic [KEY_IDX_W-1:0]   in_idx;
  logic [WAIT_ADDR_W-1:0] ws_raddr;
  logic [TASK_W-1:0]      ws_rdata;
  logic                   byp_hit_q;
  logic [TASK_W-1:0]      byp_data_q;
  logic [TASK_W-1:0]      wait_data;

  // The operation register moves on when the result register is empty or being drained.
  assign res_ready  = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && res_ready;
  assign in_stall_o = s1_valid_q && !res_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_kind_q <= kind_i;
      s1_key_q  <= key_i;
      s1_task_q <= task_id_i;
    end
  end

  // Key lookup for the operation in flight.
  assign s1_idx      = s1_key_q[KEY_IDX_W-1:0];
  assign s1_in_range = (32'(s1_key_q) < NUM_KEYS);
  assign s1_key_ok   = s1_in_range && key_known_q[s1_idx];
  assign s1_wh       = wait_head_q[s1_idx];
  assign s1_wc       = wait_count_q[s1_idx];

  assign wait_tail_sum  = (WAIT_CNT_W + 1)'(s1_wh) + (WAIT_CNT_W + 1)'(s1_wc);
  assign wait_tail      = (wait_tail_sum >= (WAIT_CNT_W + 1)'(WAIT_DEPTH))
                        ? WAIT_PTR_W'(wait_tail_sum - (WAIT_CNT_W + 1)'(WAIT_DEPTH))
                        : WAIT_PTR_W'(wait_tail_sum);
  assign wait_head_next = (32'(s1_wh) == WAIT_DEPTH - 1) ? '0 : s1_wh + 1'b1;

  // Ready deque pointers: front slot for a push to the front, tail slot for a push to the back.
  assign ready_full     = (ready_count_q == READY_CNT_W'(READY_DEPTH));
  assign ready_front    = (ready_head_q == '0) ? READY_PTR_W'(READY_DEPTH - 1)
                                               : ready_head_q - 1'b1;
  assign ready_tail_sum = (READY_CNT_W + 1)'(ready_head_q) + (READY_CNT_W + 1)'(ready_count_q);
  assign ready_tail     = (ready_tail_sum >= (READY_CNT_W + 1)'(READY_DEPTH))
                        ? READY_PTR_W'(ready_tail_sum - (READY_CNT_W + 1)'(READY_DEPTH))
                        : READY_PTR_W'(ready_tail_sum);

  assign wait_data = byp_hit_q ? byp_data_q : ws_rdata;

  // Operation execution: every change of state happens only on the cycle the operation retires.
  always_comb begin
    key_known_d    = key_known_q;
    key_free_d     = key_free_q;
    wait_head_d    = wait_head_q;
    wait_count_d   = wait_count_q;
    ready_head_d   = ready_head_q;
    ready_count_d  = ready_count_q;
    rs_we          = 1'b0;
    rs_waddr       = ready_front;
    rs_wdata       = s1_task_q;
    ws_we          = 1'b0;
    ws_waddr       = wait_addr(s1_idx, wait_tail);
    res_task_valid = 1'b0;
    res_task       = '0;
    res_status     = ST_OK;

    if (s1_fire) begin
      unique case (kind_e'(s1_kind_q))
        KIND_PLAIN: begin
          if (ready_full) begin
            res_status = ST_READY_FULL;
          end else begin
            rs_we         = 1'b1;
            rs_waddr      = ready_tail;
            ready_count_d = ready_count_q + 1'b1;
          end
        end
        KIND_KEYED: begin
          if (!s1_key_ok) begin
            res_status = ST_KEY_UNINIT;
          end else if (key_free_q[s1_idx]) begin
            if (ready_full) begin
              res_status = ST_READY_FULL;
            end else begin
              rs_we              = 1'b1;
              ready_head_d       = ready_front;
              ready_count_d      = ready_count_q + 1'b1;
              key_free_d[s1_idx] = 1'b0;
            end
          end else if (s1_wc == WAIT_CNT_W'(WAIT_DEPTH)) begin
            res_status = ST_WAIT_FULL;
          end else begin
            ws_we                = 1'b1;
            wait_count_d[s1_idx] = s1_wc + 1'b1;
          end
        end
        KIND_RELEASE: begin
          if (!s1_key_ok) begin
            res_status = ST_KEY_UNINIT;
          end else if (s1_wc == '0) begin
            key_free_d[s1_idx] = 1'b1;
          end else if (ready_full) begin
            res_status = ST_READY_FULL;
          end else begin
            // The oldest waiting task was read from memory when this operation was accepted.
            rs_we                = 1'b1;
            rs_wdata             = wait_data;
            ready_head_d         = ready_front;
            ready_count_d        = ready_count_q + 1'b1;
            wait_head_d[s1_idx]  = wait_head_next;
            wait_count_d[s1_idx] = s1_wc - 1'b1;
          end
        end
        KIND_DEQUEUE: begin
          if (ready_count_q == '0) begin
            res_status = ST_READY_EMPTY;
          end else begin
            res_task_valid = 1'b1;
            res_task       = ready_store_q[ready_head_q];
            ready_head_d   = (32'(ready_head_q) == READY_DEPTH - 1) ? '0
                                                                    : ready_head_q + 1'b1;
            ready_count_d  = ready_count_q - 1'b1;
          end
        end
        KIND_INIT: begin
          if (!s1_in_range) begin
            res_status = ST_KEY_UNINIT;
          end else begin
            key_known_d[s1_idx]  = 1'b1;
            key_free_d[s1_idx]   = 1'b1;
            wait_head_d[s1_idx]  = '0;
            wait_count_d[s1_idx] = '0;
          end
        end
        default: begin
          // Unused operation codes change nothing and report success.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_head_q  <= '0;
      ready_count_q <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_known_q[i]  <= 1'b0;
        key_free_q[i]   <= 1'b0;
        wait_head_q[i]  <= '0;
        wait_count_q[i] <= '0;
      end
    end else begin
      ready_head_q  <= ready_head_d;
      ready_count_q <= ready_count_d;
      key_known_q   <= key_known_d;
      key_free_q    <= key_free_d;
      wait_head_q   <= wait_head_d;
      wait_count_q  <= wait_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rs_we) begin
      ready_store_q[rs_waddr] <= rs_wdata;
    end
  end

  // The waiting memory is read at acceptance, at the head the key will have once the
  // retiring operation has updated it. A write by that same operation to the entry being
  // read is caught by the bypass register.
  assign in_idx   = key_i[KEY_IDX_W-1:0];
  assign ws_raddr = wait_addr(in_idx, wait_head_d[in_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_hit_q <= 1'b0;
    end else if (in_accept) begin
      byp_hit_q <= ws_we && (ws_waddr == ws_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byp_data_q <= s1_task_q;
    end
  end

  ksts_ram #(
    .WIDTH(TASK_W),
    .DEPTH(WAIT_ENTRIES)
  ) u_wait_ram (
    .clk_i  (clk_i),
    .we_i   (ws_we),
    .waddr_i(ws_waddr),
    .wdata_i(s1_task_q),
    .re_i   (in_accept),
    .raddr_i(ws_raddr),
    .rdata_o(ws_rdata)
  );

  // Result register: loads when an operation retires, drains on an output transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      task_valid_q <= res_task_valid;
      task_out_q   <= res_task;
      status_q     <= res_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign task_valid_o = task_valid_q;
  assign task_out_o   = task_out_q;
  assign status_o     = status_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ready_count_q) <= READY_DEPTH)
    else $error("ready queue count exceeds its depth");

  a_task_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && task_valid_o |-> status_o == ST_OK)
    else $error("returned task without ok status");

  a_task_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !task_valid_o |-> task_out_o == '0)
    else $error("task output not zero without a returned task");

  a_deq_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_kind_q == KIND_DEQUEUE && ready_count_q != '0
      |=> out_valid_o && task_valid_o)
    else $error("dequeue on a non-empty queue returned no task");
`endif

endmodule

// File: src/ksts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ksts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
